// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/core/ils_pkg.sv =====
// Package: sizes, command codes, FSM states and control/status structs.
package ils_pkg;

	localparam int DEPTH = 16;
	localparam int LEN_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int DATA_W = 32;
	localparam int CMD_W = 2;
	localparam int POS_W = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 2'd0,
		CMD_PUSH_BACK  = 2'd1,
		CMD_DELETE     = 2'd2
	} ils_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} ils_state_t;

	typedef struct packed {
		logic accept;   // take the input item and apply it
		logic load;     // load the next dump result into the output register
	} ils_cmd_t;

	typedef struct packed {
		logic last;     // current dump entry is the final one
		logic out_free; // output register can take a result this cycle
	} ils_stat_t;

endpackage

// ===== rtl/core/ils_ctrl.sv =====
// Controller: idle/dump state machine driving the datapath.
module ils_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ils_pkg::ils_stat_t stat,
	output ils_pkg::ils_cmd_t  cmd
);
	import ils_pkg::*;

	ils_state_t state_q;
	ils_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_DUMP;
			end
			ST_DUMP: begin
				if (stat.out_free && stat.last) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		cmd.accept = 1'b0;
		cmd.load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			ST_DUMP: begin
				cmd.load = stat.out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

// ===== rtl/core/ils_dp.sv =====
// Datapath: entry registers, length, dump index and output register.
module ils_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ils_pkg::ils_cmd_t                   cmd,
	output ils_pkg::ils_stat_t                  stat,
	input  logic [ils_pkg::CMD_W-1:0]           in_cmd,
	input  logic signed [ils_pkg::DATA_W-1:0]   in_value,
	input  logic [ils_pkg::POS_W-1:0]           in_position,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [ils_pkg::DATA_W-1:0]  out_element,
	output logic                               out_is_last,
	output logic                               out_list_empty,
	output logic                               out_dropped
);
	import ils_pkg::*;

	logic [DATA_W-1:0] entries_q [DEPTH];
	logic [LEN_W-1:0]  length_q;
	logic [IDX_W-1:0]  idx_q;
	logic              drop_q;
	logic              out_valid_q;

	logic              full;
	logic              is_front;
	logic              is_back;
	logic              is_del;
	logic              del_hit;
	logic              empty;

	assign full     = (length_q == LEN_W'(DEPTH));
	assign is_front = (in_cmd == CMD_PUSH_FRONT);
	assign is_back  = (in_cmd == CMD_PUSH_BACK);
	assign is_del   = (in_cmd == CMD_DELETE);
	assign del_hit  = is_del && (in_position < POS_W'(length_q));
	assign empty    = (length_q == '0);

	// Entries shift up on front insert, down on delete; back insert fills in place.
	for (genvar g = 0; g < DEPTH; g++) begin : g_ent
		logic [DATA_W-1:0] below;
		logic [DATA_W-1:0] above;
		if (g == 0) begin : g_lo
			assign below = in_value;
		end else begin : g_mid
			assign below = entries_q[g-1];
		end
		if (g == DEPTH - 1) begin : g_hi
			assign above = entries_q[g];
		end else begin : g_top
			assign above = entries_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.accept) begin
				if (is_front && !full && (LEN_W'(g) <= length_q)) begin
					entries_q[g] <= below;
				end else if (is_back && !full && (LEN_W'(g) == length_q)) begin
					entries_q[g] <= in_value;
				end else if (del_hit && (POS_W'(g) >= in_position)
						&& (LEN_W'(g + 1) < length_q)) begin
					entries_q[g] <= above;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
			idx_q    <= '0;
			drop_q   <= 1'b0;
		end else if (cmd.accept) begin
			idx_q  <= '0;
			drop_q <= (is_front || is_back) && full;
			if ((is_front || is_back) && !full) begin
				length_q <= length_q + LEN_W'(1);
			end else if (del_hit) begin
				length_q <= length_q - LEN_W'(1);
			end
		end else if (cmd.load) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	assign stat.last     = empty || ((LEN_W'(idx_q) + LEN_W'(1)) == length_q);
	assign stat.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_element    <= empty ? '0 : entries_q[idx_q];
			out_is_last    <= stat.last;
			out_list_empty <= empty;
			out_dropped    <= drop_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/indexed_list_store.sv =====
// Top level: ordered store of signed words with front/back insert and positional delete.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  in      | into      | in_valid / in_stall  | cmd, value, position
//  out     | out of    | out_valid / out_stall| element, is_last, list_empty, dropped
//
// An item is applied to the entry registers in the cycle it is accepted; the dump
// then moves one result per cycle through the single output register while
// out_stall is low.
// in_stall stays high while a dump is in progress; the next item is taken as soon
// as the final result sits in the output register, even if it waits there.
// out_stall holds the output register and pauses the dump walk.
// Reset clears the length, dump state and output valid; entry contents are not reset.
module indexed_list_store (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [ils_pkg::CMD_W-1:0]          cmd,
	input  logic signed [ils_pkg::DATA_W-1:0]  value,
	input  logic [ils_pkg::POS_W-1:0]          position,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [ils_pkg::DATA_W-1:0] element,
	output logic                              is_last,
	output logic                              list_empty,
	output logic                              dropped
);
	import ils_pkg::*;

	// Commands from the controller, status back from the datapath.
	ils_cmd_t  dp_cmd;
	ils_stat_t dp_stat;

	// State machine: accepts one item, then walks the dump until the last entry.
	ils_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	// Entry registers with shift-on-insert/delete, length, dump index, output register.
	ils_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (dp_cmd),
		.stat           (dp_stat),
		.in_cmd         (cmd),
		.in_value       (value),
		.in_position    (position),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_element    (element),
		.out_is_last    (is_last),
		.out_list_empty (list_empty),
		.out_dropped    (dropped)
	);

endmodule

// ===== rtl/core/ils_chk.sv =====
// Port-level checker for indexed_list_store, bound to the top level.
module ils_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [ils_pkg::DATA_W-1:0] element,
	input logic                              is_last,
	input logic                              list_empty,
	input logic                              dropped
);
	import ils_pkg::*;

`include "assert_macros.svh"

	// A held result stays offered.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)

	// An accepted item raises in_stall, blocking further items while its dump runs.
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)

	// The empty marker is a single, final, zero result.
	`ASSERT_SAME(a_empty_form, clk, arst_n, out_valid && list_empty,
		is_last && (element == '0))

	// A refused insert only happens on a full store, never on an empty one.
	`ASSERT_SAME(a_empty_no_drop, clk, arst_n, out_valid && list_empty, !dropped)

endmodule

bind indexed_list_store ils_chk u_ils_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.element    (element),
	.is_last    (is_last),
	.list_empty (list_empty),
	.dropped    (dropped)
);

// ===== tb/tb_indexed_list_store.sv =====
// Testbench for indexed_list_store: directed and random commands, with every dump checked.
`timescale 1ns / 100ps

module tb_indexed_list_store;

	import ils_pkg::*;

	// Per-cycle idle chance of each side, in percent.
	localparam int IDLE_PCT = 24;
	// Number of random commands.
	localparam int RANDOM_ITEMS = 255;
	// Settle time after the last result: more than a full dump.
	localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
	// Hard stop, far above the slowest legal run.
	localparam int CYCLE_LIMIT = 200000;
	// Command code the block does not define; it must leave the list alone.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		logic signed [DATA_W-1:0] element;
		logic                     is_last;
		logic                     list_empty;
		logic                     dropped;
	} dump_entry_t;

	logic                     clk = 1'b1;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [CMD_W-1:0]         cmd = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic [POS_W-1:0]         position = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [DATA_W-1:0] element;
	logic                     is_last;
	logic                     list_empty;
	logic                     dropped;

	// Shadow copy of the stored sequence, front at index 0.
	logic signed [DATA_W-1:0] list_shadow[$];
	// Results still owed by the block, oldest first.
	dump_entry_t              pending_dump[$];
	dump_entry_t              want;

	// When set, neither side idles.
	bit quiet = 1'b0;
	int fail_count = 0;
	int cycle_count = 0;

	logic signed [DATA_W-1:0] corner_values[4] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1};

	indexed_list_store dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.value      (value),
		.position   (position),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.element    (element),
		.is_last    (is_last),
		.list_empty (list_empty),
		.dropped    (dropped)
	);

	always begin
		#6 clk = 1'b0;
		#6 clk = 1'b1;
	end

	// Apply one accepted command to the shadow list and queue the dump it causes.
	function automatic void apply_command(logic [CMD_W-1:0] op, logic signed [DATA_W-1:0] v,
			logic [POS_W-1:0] p);
		dump_entry_t e;
		logic        drop;
		drop = 1'b0;
		case (op)
			CMD_PUSH_FRONT: begin
				if (list_shadow.size() >= DEPTH)
					drop = 1'b1;
				else
					list_shadow.push_front(v);
			end
			CMD_PUSH_BACK: begin
				if (list_shadow.size() >= DEPTH)
					drop = 1'b1;
				else
					list_shadow.push_back(v);
			end
			CMD_DELETE: begin
				// positions at or past the length are no-ops
				if (int'(p) < list_shadow.size())
					list_shadow.delete(int'(p));
			end
			default: ;
		endcase
		if (list_shadow.size() == 0) begin
			// empty list dumps a single zero flagged empty
			e.element = '0;
			e.is_last = 1'b1;
			e.list_empty = 1'b1;
			e.dropped = drop;
			pending_dump.push_back(e);
		end else begin
			foreach (list_shadow[i]) begin
				e.element = list_shadow[i];
				e.is_last = (i == list_shadow.size() - 1);
				e.list_empty = 1'b0;
				e.dropped = drop;
				pending_dump.push_back(e);
			end
		end
	endfunction

	// Offer one command, idling at random first, and wait for the handshake.
	task automatic send_item(logic [CMD_W-1:0] op, logic signed [DATA_W-1:0] v,
			logic [POS_W-1:0] p);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		value <= v;
		position <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		apply_command(op, v, p);
	endtask

	// Hold off the sender until every owed result has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_dump.size() != 0)
			@(posedge clk);
	endtask

	// Empty list: delete with the lowest position, and the unused code with the highest.
	task automatic test_empty_list();
		send_item(CMD_DELETE, 32'sh0, 16'h0000);
		send_item(CMD_UNUSED, -32'sd1, 16'hFFFF);
	endtask

	// Fill to capacity from both ends with corner values, then overflow on each end.
	task automatic test_fill_and_overflow();
		logic signed [DATA_W-1:0] fill_values[DEPTH];
		fill_values = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1,
			32'sh5555_5555, 32'shAAAA_AAAA, 32'sh1, -32'sd2,
			32'sh0F0F_0F0F, 32'shF0F0_F0F0, 32'sh1234_5678, 32'shFEDC_BA98,
			32'sh0000_FFFF, 32'shFFFF_0000, 32'sh4000_0000, 32'shC000_0000};
		foreach (fill_values[i])
			send_item((i % 2) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, fill_values[i], 16'h5A5A);
		// full now: both inserts must be refused and flagged
		send_item(CMD_PUSH_FRONT, 32'sh7777_7777, 16'h0);
		send_item(CMD_PUSH_BACK, 32'sh8888_8888, 16'hFFFF);
	endtask

	// Deletes at the tail, the head, the middle, and past the end.
	task automatic test_delete_positions();
		send_item(CMD_DELETE, 32'sh0, POS_W'(DEPTH - 1));
		send_item(CMD_DELETE, -32'sd1, 16'h0000);
		send_item(CMD_DELETE, 32'sh0, 16'd7);
		send_item(CMD_DELETE, 32'sh0, POS_W'(list_shadow.size()));
		send_item(CMD_DELETE, 32'sh0, 16'hFFFF);
	endtask

	// Random commands: biased to fill up and drain down in turns so that the
	// full and empty corners come round often; most deletes hit a live entry.
	task automatic test_random_traffic();
		bit                       grow;
		int                       len;
		int                       roll;
		logic [CMD_W-1:0]         op;
		logic signed [DATA_W-1:0] v;
		logic [POS_W-1:0]         p;
		grow = 1'b1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			len = list_shadow.size();
			if (len == DEPTH && $urandom_range(3) == 0)
				grow = 1'b0;
			else if (len == 0 && $urandom_range(2) == 0)
				grow = 1'b1;
			// stretch with no idling on either side
			quiet = (n >= 60 && n < 110);
			// sender waits out every owed result once mid-run
			if (n == 180)
				wait_drained();
			roll = $urandom_range(99);
			if (roll < 4)
				op = CMD_UNUSED;
			else if (roll < (grow ? 74 : 30))
				op = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
			else
				op = CMD_DELETE;
			roll = $urandom_range(9);
			if (len > 0 && roll < 8)
				p = POS_W'($urandom_range(len - 1));
			else if (roll < 9)
				p = POS_W'(len + int'($urandom_range(2)));
			else
				p = POS_W'($urandom_range(16'hFFFF));
			v = ($urandom_range(6) == 0) ? corner_values[$urandom_range(3)] : $urandom;
			send_item(op, v, p);
		end
		quiet = 1'b0;
	endtask

	// Result side: random stall, and each taken result checked against the oldest owed one.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_dump.size() == 0) begin
				$error("result with none owed: element %0d is_last %0b", element, is_last);
				fail_count++;
			end else begin
				want = pending_dump.pop_front();
				if (element !== want.element) begin
					$error("element: expected %0d, got %0d", want.element, element);
					fail_count++;
				end
				if (is_last !== want.is_last) begin
					$error("is_last: expected %0b, got %0b", want.is_last, is_last);
					fail_count++;
				end
				if (list_empty !== want.list_empty) begin
					$error("list_empty: expected %0b, got %0b", want.list_empty, list_empty);
					fail_count++;
				end
				if (dropped !== want.dropped) begin
					$error("dropped: expected %0b, got %0b", want.dropped, dropped);
					fail_count++;
				end
			end
		end
		out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_fill_and_overflow();
		test_delete_positions();
		test_random_traffic();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
